FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the block's checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/hff_pkg.sv
// ---------------------------------------------------------------------------
// hff_pkg
// Types, limits and microcode program of the hex field formatter.
// ---------------------------------------------------------------------------
package hff_pkg;

    localparam int MAX_WIDTH     = 60;
    localparam int MAX_PRECISION = 52;
    localparam int CNT_W         = 6;
    localparam int STEP_W        = 3;

    localparam logic [1:0] PAD_LEFT  = 2'd0;
    localparam logic [1:0] PAD_ZERO  = 2'd1;
    localparam logic [1:0] PAD_RIGHT = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    typedef logic [STEP_W-1:0] t_step;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [1:0] {
        OP_WAIT,
        OP_LOAD,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        SRC_SPACE,
        SRC_ZERO,
        SRC_X,
        SRC_DIGIT
    } t_src;

    typedef enum logic [2:0] {
        CSEL_NONE,
        CSEL_PRE_PAD,
        CSEL_PREFIX,
        CSEL_FILL,
        CSEL_LEN,
        CSEL_POST_PAD
    } t_csel;

    typedef enum logic [1:0] {
        LAST_NONE,
        LAST_NO_POST,
        LAST_END
    } t_last;

    typedef struct packed {
        t_op   op;
        t_src  src;
        t_csel csel;
        t_last last;
        t_step nxt;
    } t_uword;

    // Per-transaction segment lengths, already gated by mode and precision.
    typedef struct packed {
        t_cnt       pre_pad;
        t_cnt       fill;
        logic [3:0] len;
        t_cnt       post_pad;
        logic       alt;
        logic       upper;
    } t_plan;

    // Step map: wait, load, pre-pad, '0', 'x', zero fill, digits, post-pad.
    function automatic t_uword ucode_rom(input t_step s);
        t_uword w;
        case (s)
            3'd0:    w = '{OP_WAIT, SRC_SPACE, CSEL_NONE,     LAST_NONE,    3'd1};
            3'd1:    w = '{OP_LOAD, SRC_SPACE, CSEL_NONE,     LAST_NONE,    3'd2};
            3'd2:    w = '{OP_EMIT, SRC_SPACE, CSEL_PRE_PAD,  LAST_NONE,    3'd3};
            3'd3:    w = '{OP_EMIT, SRC_ZERO,  CSEL_PREFIX,   LAST_NONE,    3'd4};
            3'd4:    w = '{OP_EMIT, SRC_X,     CSEL_PREFIX,   LAST_NONE,    3'd5};
            3'd5:    w = '{OP_EMIT, SRC_ZERO,  CSEL_FILL,     LAST_NONE,    3'd6};
            3'd6:    w = '{OP_EMIT, SRC_DIGIT, CSEL_LEN,      LAST_NO_POST, 3'd7};
            3'd7:    w = '{OP_EMIT, SRC_SPACE, CSEL_POST_PAD, LAST_END,     3'd0};
            default: w = '{OP_WAIT, SRC_SPACE, CSEL_NONE,     LAST_NONE,    3'd0};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else if (upper) begin
            c = 8'h41 + {4'd0, nib - 4'd10};
        end else begin
            c = 8'h61 + {4'd0, nib - 4'd10};
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/hff_if.sv
// ---------------------------------------------------------------------------
// hff channel interfaces
// Valid/ready channels for the format request and the character stream.
// ---------------------------------------------------------------------------
interface hff_in_if;
    logic              valid;
    logic              ready;
    logic [31:0]       value;
    logic              upper_case;
    logic              alt_form;
    logic [1:0]        pad_mode;
    logic [5:0]        field_width;
    logic signed [6:0] precision;

    modport source (output valid, value, upper_case, alt_form, pad_mode,
                    field_width, precision, input ready);
    modport sink   (input valid, value, upper_case, alt_form, pad_mode,
                    field_width, precision, output ready);
endinterface

interface hff_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, out_char, last, input ready);
    modport sink   (input valid, out_char, last, output ready);
endinterface

FILE: rtl/core/hex_field_formatter_unit.sv
// ---------------------------------------------------------------------------
// hex_field_formatter_unit
// printf-style %x / %X conversion with width, precision and 0x prefix.
// ---------------------------------------------------------------------------
// Takes one request (32-bit value plus format settings) and streams the
// formatted field out one ASCII character per transaction, flagging the
// final character with last. Requests are handled one at a time: a new one
// is accepted only once the previous field has been fully handed to the
// output register. The microcode sequencer accepts the request in its wait
// step and loads the first segment count in its load step, then walks the
// six segments, left pad, '0', 'x', zero fill, digits and right pad,
// emitting each segment's characters in turn and passing through empty
// segments without emitting. The pace is set by the single character
// output port. The output register lets the sequencer keep producing
// while the sink takes the previous character, so with ready held high
// there are no stall bubbles. Control comes from an eight-step microcode
// table in hff_pkg; each step names its character source, its repeat
// count and its last-flag rule.
// ---------------------------------------------------------------------------
module hex_field_formatter_unit import hff_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    hff_in_if.sink    i_in,
    hff_out_if.source o_out
);

    // sequencer state
    t_step      r_step, n_step;
    t_cnt       r_cnt, n_cnt;
    t_plan      r_plan;
    logic [31:0] r_value;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;

    t_plan      plan_c;
    t_uword     uword;
    t_uword     uword_nxt;
    logic       out_free;
    logic       emit_fire;
    logic       advance;
    logic [2:0] dig_idx;
    logic [7:0] emit_char;
    logic       emit_last;

    hff_plan u_plan (
        .i_value       (i_in.value),
        .i_upper_case  (i_in.upper_case),
        .i_alt_form    (i_in.alt_form),
        .i_pad_mode    (i_in.pad_mode),
        .i_field_width (i_in.field_width),
        .i_precision   (i_in.precision),
        .o_plan        (plan_c)
    );

    assign uword     = ucode_rom(r_step);
    assign out_free  = !r_out_valid || o_out.ready;
    assign emit_fire = (uword.op == OP_EMIT) && (r_cnt != '0) && out_free;

    // next step and repeat counter
    always_comb begin
        advance = 1'b0;
        n_cnt   = r_cnt;
        case (uword.op)
            OP_WAIT: begin
                advance = i_in.valid;
            end
            OP_LOAD: begin
                advance = 1'b1;
            end
            OP_EMIT: begin
                if (emit_fire) begin
                    n_cnt = r_cnt - 6'd1;
                end
                advance = (r_cnt == '0) || (emit_fire && r_cnt == 6'd1);
            end
            default: begin
                advance = 1'b1;
            end
        endcase

        n_step    = advance ? uword.nxt : r_step;
        uword_nxt = ucode_rom(uword.nxt);
        if (advance) begin
            // entering a step loads its segment length
            case (uword_nxt.csel)
                CSEL_PRE_PAD:  n_cnt = r_plan.pre_pad;
                CSEL_PREFIX:   n_cnt = {5'd0, r_plan.alt};
                CSEL_FILL:     n_cnt = r_plan.fill;
                CSEL_LEN:      n_cnt = {2'd0, r_plan.len};
                CSEL_POST_PAD: n_cnt = r_plan.post_pad;
                default:       n_cnt = '0;
            endcase
        end
    end

    // character and last flag for the current step
    always_comb begin
        // digits go out most significant first; count-1 is the nibble index
        dig_idx = r_cnt[2:0] - 3'd1;
        case (uword.src)
            SRC_SPACE: emit_char = CH_SPACE;
            SRC_ZERO:  emit_char = CH_ZERO;
            SRC_X:     emit_char = r_plan.upper ? CH_X_UP : CH_X_LO;
            SRC_DIGIT: emit_char = hex_char(r_value[4*dig_idx +: 4], r_plan.upper);
            default:   emit_char = CH_SPACE;
        endcase
        case (uword.last)
            LAST_NO_POST: emit_last = (r_cnt == 6'd1) && (r_plan.post_pad == '0);
            LAST_END:     emit_last = (r_cnt == 6'd1);
            default:      emit_last = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            r_cnt  <= n_cnt;
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_plan  <= plan_c;
            r_value <= i_in.value;
        end
        if (emit_fire) begin
            r_out_char <= emit_char;
            r_out_last <= emit_last;
        end
    end

    // no request is taken while reset is held
    assign i_in.ready     = i_rst_n && (uword.op == OP_WAIT);
    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.last     = r_out_last;

endmodule

FILE: rtl/core/hff_plan.sv
// ---------------------------------------------------------------------------
// hff_plan
// Turns one format request into the lengths of the field's segments.
// ---------------------------------------------------------------------------
module hff_plan import hff_pkg::*; (
    input  logic [31:0]       i_value,
    input  logic              i_upper_case,
    input  logic              i_alt_form,
    input  logic [1:0]        i_pad_mode,
    input  logic [5:0]        i_field_width,
    input  logic signed [6:0] i_precision,
    output t_plan             o_plan
);

    logic [5:0]        width_c;
    logic [3:0]        len;
    logic              prec_given;
    logic [5:0]        prec_eff;
    logic [5:0]        zeros_p;
    logic [5:0]        body;
    logic signed [7:0] w_eff;
    logic [5:0]        pad;

    always_comb begin
        width_c = (i_field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : i_field_width;

        // highest nonzero nibble sets the digit count, at least one
        len = 4'd1;
        for (int k = 0; k < 8; k++) begin
            if (i_value[4*k +: 4] != 4'd0) begin
                len = 4'(k + 1);
            end
        end

        // -1 means no precision; other negatives act as zero
        prec_given = (i_precision != -7'sd1);
        if (i_precision[6]) begin
            prec_eff = 6'd0;
        end else if (i_precision[5:0] > 6'(MAX_PRECISION)) begin
            prec_eff = 6'(MAX_PRECISION);
        end else begin
            prec_eff = i_precision[5:0];
        end

        zeros_p = (prec_eff > {2'd0, len}) ? prec_eff - {2'd0, len} : 6'd0;
        body    = prec_given ? zeros_p + {2'd0, len} : {2'd0, len};

        // prefix eats two columns; may go negative
        w_eff = $signed({2'd0, width_c}) - (i_alt_form ? 8'sd2 : 8'sd0);
        pad   = (w_eff > $signed({2'd0, body})) ? 6'(w_eff - $signed({2'd0, body})) : 6'd0;

        o_plan.pre_pad  = ((!prec_given && i_pad_mode == PAD_LEFT) ||
                           (prec_given && (i_pad_mode == PAD_LEFT ||
                                           i_pad_mode == PAD_ZERO))) ? pad : 6'd0;
        o_plan.fill     = prec_given ? zeros_p :
                          ((i_pad_mode == PAD_ZERO) ? pad : 6'd0);
        o_plan.len      = len;
        o_plan.post_pad = (i_pad_mode == PAD_RIGHT) ? pad : 6'd0;
        o_plan.alt      = i_alt_form;
        o_plan.upper    = i_upper_case;
    end

endmodule

FILE: rtl/core/hff_checker.sv
// ---------------------------------------------------------------------------
// hff_checker
// Port-level checks on the hex field formatter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hff_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);

    // stalled transaction stays offered and unchanged
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_char) && $stable(i_out_last))
    // a field in progress blocks new requests
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `ASSERT_IMPL(a_no_accept_mid_field, i_clk, i_rst_n, i_out_valid && !i_out_last, !i_in_ready)

endmodule

bind hex_field_formatter_unit hff_checker u_hff_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.out_char),
    .i_out_last  (o_out.last)
);
